/* sv/tpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_pkg: shared types and constants of the test pattern pixel generator
// Field widths, register indexes, fixed colors and the color wheel lookup.
// ----------------------------------------------------------------------------
package tpg_pkg;

  // Field widths
  localparam int X_W       = 8;
  localparam int Y_W       = 10;
  localparam int FRAME_W   = 16;
  localparam int COLOR_W   = 16;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;

  // 5*frame needs three more bits than the frame count
  localparam int DVD_W = FRAME_W + 3;

  // Defaults for the top level parameters
  localparam int MAX_WIDTH_DEF   = 240;
  localparam int SQUARE_SIZE_DEF = 42;

  // Square border thickness, stripe length in lines
  localparam int BORDER_PX  = 3;
  localparam int STRIPE_LEN = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;

  // Register reset values
  localparam logic [X_W-1:0] RESET_WIDTH  = 8'd240;
  localparam logic [Y_W-1:0] RESET_HEIGHT = 10'd240;

  // Fixed colors, RGB565
  localparam logic [COLOR_W-1:0] COLOR_WHITE  = 16'hFFFF;
  localparam logic [COLOR_W-1:0] COLOR_BLACK  = 16'h0000;
  localparam logic [COLOR_W-1:0] COLOR_YELLOW = 16'hFF24;

  // Color wheel segments
  localparam logic [1:0] SEG_RED_GREEN  = 2'd0;
  localparam logic [1:0] SEG_GREEN_BLUE = 2'd1;
  localparam logic [1:0] SEG_BLUE_RED   = 2'd2;

  // Per-item data carried alongside the remainder pipelines
  typedef struct packed {
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [COLOR_W-1:0] wheel_color;
    logic               stripe;
  } tpg_side_t;

  // Keep the top 5/6/5 bits of 8-bit red/green/blue
  function automatic logic [COLOR_W-1:0] pack565(input logic [7:0] r,
                                                 input logic [7:0] g,
                                                 input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // Wheel color from segment and position within the 64-step segment
  function automatic logic [COLOR_W-1:0] wheel565(input logic [1:0] seg,
                                                  input logic [5:0] pos);
    logic [7:0] up;
    logic [7:0] dn;
    logic [COLOR_W-1:0] c;
    up = {pos, 2'b00};
    dn = ~up;  // 255 - 4*pos
    case (seg)
      SEG_RED_GREEN:  c = pack565(dn, up, 8'd32);
      SEG_GREEN_BLUE: c = pack565(8'd16, dn, up);
      SEG_BLUE_RED:   c = pack565(up, 8'd40, dn);
      default:        c = pack565(up, 8'd40, dn);
    endcase
    return c;
  endfunction

endpackage

/* sv/tpg_mod_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_mod_pipe: pipelined remainder unit
// Restoring division, one dividend bit per stage; remainder from the last of
// DVD_W stages. Unenforced: hold the divisor steady while items are in flight.
// ----------------------------------------------------------------------------
module tpg_mod_pipe #(
  parameter int DVD_W = 19,
  parameter int DIV_W = 10
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] remainder
);

  logic [DIV_W-1:0] rem [DVD_W];
  logic [DVD_W-1:0] dvd [DVD_W-1];

  genvar k;
  for (k = 0; k < DVD_W; k++) begin : g_step
    logic [DIV_W-1:0] rem_in;
    logic [DVD_W-1:0] dvd_in;
    logic [DIV_W:0]   cand;

    if (k == 0) begin : g_head
      assign rem_in = '0;
      assign dvd_in = dividend;
    end else begin : g_body
      assign rem_in = rem[k-1];
      assign dvd_in = dvd[k-1];
    end

    // Shift in the next dividend bit, subtract when it fits
    assign cand = {rem_in, dvd_in[DVD_W-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (cand >= {1'b0, divisor}) begin
          rem[k] <= DIV_W'(cand - {1'b0, divisor});
        end else begin
          rem[k] <= DIV_W'(cand);
        end
      end
    end

    // Remaining dividend bits move on with the partial remainder
    if (k < DVD_W - 1) begin : g_dvd
      always_ff @(posedge clk) begin
        if (en) begin
          dvd[k] <= {dvd_in[DVD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign remainder = rem[DVD_W-1];

endmodule

/* sv/test_pattern_pixel_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// test_pattern_pixel_generator: RGB565 test pattern, one pixel per item
// Color wheel background, moving square with white border, yellow stripes.
// ----------------------------------------------------------------------------
// Pipeline: input capture, dividends and sums, bit-per-stage remainder pipelines
//   for the square position, square and border test, then the output register.
// Throughput: one item per cycle; the whole pipeline stalls only while the
//   output skid register is full.
// Reset: synchronous; clears all valid bits, loads width and height to 240.
module test_pattern_pixel_generator #(
  parameter int MAX_WIDTH   = tpg_pkg::MAX_WIDTH_DEF,
  parameter int SQUARE_SIZE = tpg_pkg::SQUARE_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // config
  input  logic                            cfg_write,
  input  logic [tpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpg_pkg::CFG_W-1:0]       cfg_data,
  // input items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tpg_pkg::X_W-1:0]         pixel_x,
  input  logic [tpg_pkg::Y_W-1:0]         pixel_y,
  input  logic [tpg_pkg::FRAME_W-1:0]     frame_number,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tpg_pkg::COLOR_W-1:0]     pixel_color
);

  import tpg_pkg::*;

  localparam int SIDE_N   = DVD_W - 1;   // color stage plus carry stages
  localparam int LAST     = DVD_W + 3;   // index of the final pipeline stage
  localparam int STRIPE_W = FRAME_W + 2; // y + 2*frame at full width
  localparam int CMP_W    = Y_W + 2;     // room for position + square size
  localparam int WHEEL_RECIP  = 683;     // floor(a/3) = a*683 >> 11, a < 1024
  localparam int STRIPE_RECIP = 43691;   // floor(b/3) = b*43691 >> 17, b < 2^14

  // --------------------------------------------------------------------------
  // Configuration registers and derived wrap divisors
  // --------------------------------------------------------------------------
  logic [X_W-1:0] active_width;
  logic [Y_W-1:0] active_height;
  logic [X_W-1:0] x_div;
  logic [Y_W-1:0] y_div;

  function automatic logic [X_W-1:0] wrap_x(input logic [X_W-1:0] w);
    logic [X_W-1:0] ws;
    ws = (int'(w) > MAX_WIDTH) ? X_W'(MAX_WIDTH) : w;
    if (int'(ws) <= SQUARE_SIZE) begin
      return X_W'(1);
    end
    return ws - X_W'(SQUARE_SIZE);
  endfunction

  function automatic logic [Y_W-1:0] wrap_y(input logic [Y_W-1:0] h);
    if (int'(h) <= SQUARE_SIZE) begin
      return Y_W'(1);
    end
    return h - Y_W'(SQUARE_SIZE);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= RESET_WIDTH;
      active_height <= RESET_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACTIVE_WIDTH:  active_width  <= cfg_data[X_W-1:0];
        REG_ACTIVE_HEIGHT: active_height <= cfg_data[Y_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_div <= wrap_x(RESET_WIDTH);
      y_div <= wrap_y(RESET_HEIGHT);
    end else begin
      x_div <= wrap_x(active_width);
      y_div <= wrap_y(active_height);
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance and valid bits
  // --------------------------------------------------------------------------
  logic            en;
  logic            sk_valid;
  logic [LAST:1]   stage_valid;

  assign en       = !sk_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (en) begin
      stage_valid <= {stage_valid[LAST-1:1], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input capture
  // --------------------------------------------------------------------------
  logic [X_W-1:0]     s1_x;
  logic [Y_W-1:0]     s1_y;
  logic [FRAME_W-1:0] s1_f;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x <= pixel_x;
      s1_y <= pixel_y;
      s1_f <= frame_number;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: dividends for the square position, stripe and wheel sums
  // --------------------------------------------------------------------------
  logic [X_W-1:0]      s2_x;
  logic [Y_W-1:0]      s2_y;
  logic [DVD_W-1:0]    s2_dvd_x;
  logic [DVD_W-1:0]    s2_dvd_y;
  logic [STRIPE_W-1:0] s2_sum_s;
  logic [COLOR_W-1:0]  s2_sum_p;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x     <= s1_x;
      s2_y     <= s1_y;
      s2_dvd_x <= DVD_W'({s1_f, 2'b00}) + DVD_W'(s1_f);
      s2_dvd_y <= DVD_W'({s1_f, 1'b0}) + DVD_W'(s1_f);
      s2_sum_s <= STRIPE_W'(s1_y) + STRIPE_W'({s1_f, 1'b0});
      s2_sum_p <= COLOR_W'(s1_x) + COLOR_W'(s1_y) + {s1_f[FRAME_W-3:0], 2'b00};
    end
  end

  // --------------------------------------------------------------------------
  // Square position: (5f) mod x_div and (3f) mod y_div, stages 3 to 21
  // --------------------------------------------------------------------------
  logic [X_W-1:0] rem_x;
  logic [Y_W-1:0] rem_y;

  tpg_mod_pipe #(
    .DVD_W (DVD_W),
    .DIV_W (X_W)
  ) u_mod_x (
    .clk       (clk),
    .en        (en),
    .dividend  (s2_dvd_x),
    .divisor   (x_div),
    .remainder (rem_x)
  );

  tpg_mod_pipe #(
    .DVD_W (DVD_W),
    .DIV_W (Y_W)
  ) u_mod_y (
    .clk       (clk),
    .en        (en),
    .dividend  (s2_dvd_y),
    .divisor   (y_div),
    .remainder (rem_y)
  );

  // --------------------------------------------------------------------------
  // Stage 3: mod 3 by reciprocal for wheel segment and stripe period
  // mod 192 = 64 * ((p >> 6) mod 3) + p[5:0]
  // mod 48  = 16 * ((s >> 4) mod 3) + s[3:0]
  // --------------------------------------------------------------------------
  logic [9:0]  wheel_a;
  logic [19:0] wheel_prod;
  logic [8:0]  wheel_q;
  logic [13:0] stripe_b;
  logic [30:0] stripe_prod;
  logic [13:0] stripe_q;
  logic        stripe_hit;

  assign wheel_a     = s2_sum_p[15:6];
  assign wheel_prod  = 20'(wheel_a) * 20'(WHEEL_RECIP);
  assign wheel_q     = wheel_prod[19:11];
  assign stripe_b    = s2_sum_s[STRIPE_W-1:4];
  assign stripe_prod = 31'(stripe_b) * 31'(STRIPE_RECIP);
  assign stripe_q    = stripe_prod[30:17];
  assign stripe_hit  = (stripe_b == 14'(15'(stripe_q) * 15'd3)) &&
                       (s2_sum_s[3:0] < 4'(STRIPE_LEN));

  logic [X_W-1:0] s3_x;
  logic [Y_W-1:0] s3_y;
  logic [1:0]     s3_seg;
  logic [5:0]     s3_pos;
  logic           s3_stripe;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_x      <= s2_x;
      s3_y      <= s2_y;
      s3_seg    <= 2'(wheel_a - 10'(wheel_q) * 10'd3);
      s3_pos    <= s2_sum_p[5:0];
      s3_stripe <= stripe_hit;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: wheel color; then carry until the remainders are ready
  // --------------------------------------------------------------------------
  tpg_side_t side [SIDE_N];

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{x: s3_x, y: s3_y, wheel_color: wheel565(s3_seg, s3_pos),
                   stripe: s3_stripe};
    end
  end

  genvar j;
  for (j = 1; j < SIDE_N; j++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en) begin
        side[j] <= side[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 22: square and border test
  // --------------------------------------------------------------------------
  tpg_side_t  side_last;
  logic [CMP_W-1:0] xe, ye, sxe, sye, sq, bd;
  logic in_x, in_y, edge_x, edge_y;

  assign side_last = side[SIDE_N-1];
  assign xe  = CMP_W'(side_last.x);
  assign ye  = CMP_W'(side_last.y);
  assign sxe = CMP_W'(rem_x);
  assign sye = CMP_W'(rem_y);
  assign sq  = CMP_W'(SQUARE_SIZE);
  assign bd  = CMP_W'(BORDER_PX);

  assign in_x   = (xe >= sxe) && (xe < sxe + sq);
  assign in_y   = (ye >= sye) && (ye < sye + sq);
  assign edge_x = (xe < sxe + bd) || (xe >= sxe + sq - bd);
  assign edge_y = (ye < sye + bd) || (ye >= sye + sq - bd);

  logic               s22_inside;
  logic               s22_border;
  logic               s22_stripe;
  logic [COLOR_W-1:0] s22_wheel;

  always_ff @(posedge clk) begin
    if (en) begin
      s22_inside <= in_x && in_y;
      s22_border <= in_x && in_y && (edge_x || edge_y);
      s22_stripe <= side_last.stripe;
      s22_wheel  <= side_last.wheel_color;
    end
  end

  // Color priority: border, square interior, stripe, wheel
  logic [COLOR_W-1:0] p_color;
  logic               p_valid;

  assign p_valid = stage_valid[LAST];
  assign p_color = s22_border ? COLOR_WHITE  :
                   s22_inside ? COLOR_BLACK  :
                   s22_stripe ? COLOR_YELLOW : s22_wheel;

  // --------------------------------------------------------------------------
  // Output register with skid stage
  // --------------------------------------------------------------------------
  logic [COLOR_W-1:0] sk_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end else begin
        out_valid <= p_valid;
      end
    end else if (p_valid && en) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      pixel_color <= sk_valid ? sk_color : p_color;
    end else if (p_valid && en) begin
      sk_color <= p_color;
    end
  end

`ifndef SYNTHESIS
  // Skid only fills behind an output item that was not taken
  assert property (@(posedge clk) disable iff (rst)
    $rose(sk_valid) |-> ($past(out_valid) && !$past(out_ready)))
    else $error("skid filled while output was free");

  // A held skid item always sits behind a valid output item
  assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> out_valid)
    else $error("skid holds an item with no output item ahead");

  // Wrap divisors never reach zero
  assert property (@(posedge clk) disable iff (rst)
    (x_div != '0) && (y_div != '0))
    else $error("square wrap divisor is zero");
`endif

endmodule
